[design/alu8f_pkg.sv]
package alu8f_pkg;

   // Operation codes of the request transaction
   typedef enum logic [4:0] {
      ACT_ADD    = 5'd0,
      ACT_ADC    = 5'd1,
      ACT_SUB    = 5'd2,
      ACT_SBC    = 5'd3,
      ACT_AND    = 5'd4,
      ACT_XOR    = 5'd5,
      ACT_OR     = 5'd6,
      ACT_CP     = 5'd7,
      ACT_INC    = 5'd8,
      ACT_DEC    = 5'd9,
      ACT_DAA    = 5'd10,
      ACT_CPL    = 5'd11,
      ACT_CCF    = 5'd12,
      ACT_SCF    = 5'd13,
      ACT_RLCA   = 5'd14,
      ACT_RLA    = 5'd15,
      ACT_RRCA   = 5'd16,
      ACT_RRA    = 5'd17,
      ACT_RLC    = 5'd18,
      ACT_RL     = 5'd19,
      ACT_RRC    = 5'd20,
      ACT_RR     = 5'd21,
      ACT_SLA    = 5'd22,
      ACT_SRA    = 5'd23,
      ACT_SRL    = 5'd24,
      ACT_SWAP   = 5'd25,
      ACT_BIT    = 5'd26,
      ACT_SET    = 5'd27,
      ACT_RES    = 5'd28,
      ACT_ADD16  = 5'd29,
      ACT_ADD_SP = 5'd30
   } action_type;

   // Flag bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Decimal adjust constants
   localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
   localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
   localparam logic [7:0] DAA_BYTE_MAX = 8'h99;
   localparam logic [3:0] DAA_NIB_MAX  = 4'h9;

   typedef struct packed {
      action_type  action;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [3:0]  flags_in;
      logic [2:0]  bit_index;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
   } rsp_payload_type;

endpackage

[design/alu8f_core.sv]
module alu8f_core
   import alu8f_pkg::*;
(
   input  req_payload_type req_data,
   output rsp_payload_type rsp_data
);

   logic [7:0]  a;
   logic [7:0]  b;
   logic        cin;
   logic [3:0]  fin;
   logic        c;
   logic [8:0]  sum9;
   logic [4:0]  half5;
   logic [8:0]  diff9;
   logic [4:0]  hdiff5;
   logic [7:0]  res8;
   logic [7:0]  adj;
   logic        dcy;
   logic [7:0]  mask;
   logic [16:0] sum17;
   logic [12:0] sum13;
   logic [15:0] result;
   logic [3:0]  flags;

   assign a    = req_data.operand_a[7:0];
   assign b    = req_data.operand_b[7:0];
   assign fin  = req_data.flags_in;
   assign cin  = fin[FLAG_C];
   assign mask = 8'b1 << req_data.bit_index;

   // Shared carry-in for the add and subtract families
   always_comb begin
      c = 1'b0;
      if (req_data.action == ACT_ADC || req_data.action == ACT_SBC) begin
         c = cin;
      end
   end

   assign sum9   = {1'b0, a} + {1'b0, b} + {8'b0, c};
   assign half5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, c};
   assign diff9  = {1'b0, a} - {1'b0, b} - {8'b0, c};
   assign hdiff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, c};
   assign sum17  = {1'b0, req_data.operand_a} + {1'b0, req_data.operand_b};
   assign sum13  = {1'b0, req_data.operand_a[11:0]} + {1'b0, req_data.operand_b[11:0]};

   // Decimal adjust amount and carry
   always_comb begin
      adj = 8'h00;
      dcy = cin;
      if (fin[FLAG_N]) begin
         if (fin[FLAG_H]) adj = adj + DAA_LOW_ADJ;
         if (cin) adj = adj + DAA_HIGH_ADJ;
      end else begin
         if (fin[FLAG_H] || (a[3:0] > DAA_NIB_MAX)) adj = adj + DAA_LOW_ADJ;
         if (cin || (a > DAA_BYTE_MAX)) begin
            adj = adj + DAA_HIGH_ADJ;
            dcy = 1'b1;
         end
      end
   end

   // Select the result and flags per operation
   always_comb begin
      res8   = 8'h00;
      result = req_data.operand_a;
      flags  = fin;
      case (req_data.action)
         ACT_ADD, ACT_ADC: begin
            res8   = sum9[7:0];
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, 1'b0, half5[4], sum9[8]};
         end
         ACT_SUB, ACT_SBC, ACT_CP: begin
            res8  = diff9[7:0];
            flags = {res8 == 8'h00, 1'b1, hdiff5[4], diff9[8]};
            if (req_data.action != ACT_CP) result = {8'h00, res8};
         end
         ACT_AND: begin
            res8   = a & b;
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, 1'b0, 1'b1, 1'b0};
         end
         ACT_XOR: begin
            res8   = a ^ b;
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, 3'b000};
         end
         ACT_OR: begin
            res8   = a | b;
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, 3'b000};
         end
         ACT_INC: begin
            res8   = a + 8'd1;
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
         end
         ACT_DEC: begin
            res8   = a - 8'd1;
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
         end
         ACT_DAA: begin
            res8   = fin[FLAG_N] ? (a - adj) : (a + adj);
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, fin[FLAG_N], 1'b0, dcy};
         end
         ACT_CPL: begin
            res8   = ~a;
            result = {8'h00, res8};
            flags  = {fin[FLAG_Z], 1'b1, 1'b1, cin};
         end
         ACT_CCF: flags = {fin[FLAG_Z], 1'b0, 1'b0, ~cin};
         ACT_SCF: flags = {fin[FLAG_Z], 1'b0, 1'b0, 1'b1};
         ACT_RLCA, ACT_RLC: begin
            res8   = {a[6:0], a[7]};
            result = {8'h00, res8};
            flags  = {(req_data.action == ACT_RLC) && (res8 == 8'h00), 2'b00, a[7]};
         end
         ACT_RLA, ACT_RL: begin
            res8   = {a[6:0], cin};
            result = {8'h00, res8};
            flags  = {(req_data.action == ACT_RL) && (res8 == 8'h00), 2'b00, a[7]};
         end
         ACT_RRCA, ACT_RRC: begin
            res8   = {a[0], a[7:1]};
            result = {8'h00, res8};
            flags  = {(req_data.action == ACT_RRC) && (res8 == 8'h00), 2'b00, a[0]};
         end
         ACT_RRA, ACT_RR: begin
            res8   = {cin, a[7:1]};
            result = {8'h00, res8};
            flags  = {(req_data.action == ACT_RR) && (res8 == 8'h00), 2'b00, a[0]};
         end
         ACT_SLA: begin
            res8   = {a[6:0], 1'b0};
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, 2'b00, a[7]};
         end
         ACT_SRA: begin
            res8   = {a[7], a[7:1]};
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, 2'b00, a[0]};
         end
         ACT_SRL: begin
            res8   = {1'b0, a[7:1]};
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, 2'b00, a[0]};
         end
         ACT_SWAP: begin
            res8   = {a[3:0], a[7:4]};
            result = {8'h00, res8};
            flags  = {res8 == 8'h00, 3'b000};
         end
         ACT_BIT: flags = {(a & mask) == 8'h00, 1'b0, 1'b1, cin};
         ACT_SET: begin
            res8   = a | mask;
            result = {8'h00, res8};
         end
         ACT_RES: begin
            res8   = a & ~mask;
            result = {8'h00, res8};
         end
         ACT_ADD16: begin
            result = sum17[15:0];
            flags  = {fin[FLAG_Z], 1'b0, sum13[12], sum17[16]};
         end
         ACT_ADD_SP: begin
            result = req_data.operand_a + {{8{b[7]}}, b};
            flags  = {2'b00, half5[4], sum9[8]};
         end
         default: begin
            result = req_data.operand_a;
            flags  = fin;
         end
      endcase
   end

   assign rsp_data.result    = result;
   assign rsp_data.flags_out = flags;

endmodule

[design/eight_bit_alu_with_flags_unit.sv]
// Stages: input register, then result register; the request is captured in the input register
// and the combinational ALU result is registered in the result register.
// Throughput: one transaction per cycle unless rsp_stall holds the result stage; the single ALU
// pass between the two registers sets this figure.
// Reset: synchronous, active high; clears both stage valid bits, payload registers hold.
module eight_bit_alu_with_flags_unit
   import alu8f_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic            s1_valid_ff;
   logic            s1_valid_in;
   req_payload_type s1_data_ff;
   logic            s2_valid_ff;
   logic            s2_valid_in;
   rsp_payload_type s2_data_ff;
   rsp_payload_type alu_out;
   logic            s2_load;
   logic            s1_load;

   // Advance when the stage ahead is empty or draining
   assign s2_load   = !s2_valid_ff || !rsp_stall;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   assign s1_valid_in = s1_load ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (s1_load) s1_data_ff <= req_data;
   end

   alu8f_core u_core (
      .req_data (s1_data_ff),
      .rsp_data (alu_out)
   );

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (s2_load) s2_data_ff <= alu_out;
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_data  = s2_data_ff;

   // A full input stage moving forward must fill the result stage
   a_s1_to_s2: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_load) |=> s2_valid_ff)
      else $error("result stage lost a transaction");

   // Stall only with a transaction waiting in the input stage
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

   // A stalled result must not be overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && rsp_stall) |=> (s2_valid_ff && $stable(s2_data_ff)))
      else $error("stalled result changed");

endmodule
